>>> hdl/dhdf_pkg.sv
package dhdf_pkg;

   // Field widths of the request and response payloads.
   localparam int LEN_W      = 10;
   localparam int BYTE_W     = 8;
   localparam int VERSION_W  = 4;
   localparam int ID_W       = 16;
   localparam int IP_W       = 32;
   localparam int PORT_W     = 16;
   localparam int KEY_W      = ID_W + IP_W + PORT_W;
   localparam int VERDICT_W  = 3;
   localparam int SLOT_W     = 6;

   // Packed stream widths, padded to whole bytes.
   localparam int REQ_FIELDS_W = LEN_W + 4 * BYTE_W + KEY_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = VERDICT_W + SLOT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Default depth of the recent-request table.
   localparam int DEF_TABLE_DEPTH = 64;

   // Verdict codes.
   localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT    = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_SHORT     = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_BAD_MAGIC = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_BAD_VER   = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE = 3'd4;

   // Control register map.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_FIRST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_SECOND = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_THIRD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROTO_VER    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN      = 3'd4;

   // Reset values of the control registers.
   localparam logic [BYTE_W-1:0]    RST_MAGIC       = 8'd0;
   localparam logic [VERSION_W-1:0] RST_PROTO_VER   = 4'd1;
   localparam logic [LEN_W-1:0]     RST_MIN_LEN     = 10'd8;

   // Header check settings as one bundle.
   typedef struct packed {
      logic [BYTE_W-1:0]    magic_first;
      logic [BYTE_W-1:0]    magic_second;
      logic [BYTE_W-1:0]    magic_third;
      logic [VERSION_W-1:0] protocol_version;
      logic [LEN_W-1:0]     min_header_len;
   } cfg_type;

endpackage

>>> hdl/datagram_header_and_duplicate_filter_core.sv
// Checks one datagram header per request and returns one verdict: too short,
// bad magic, bad version, duplicate or accept, in that priority. The header
// tests finish in the cycle the request is taken. A header that passes them is
// then compared against the filled entries of the recent-request table, one
// entry per cycle, through a single 64-bit comparator fed by the table's
// registered read port. The block is not ready while it searches. A header
// that fails a test goes straight to the hold state; a duplicate goes there
// from the search, and a new triple passes the write state first. The hold
// state loads the response into the output register once that register is
// free, and the next request can then be taken.
// The search stops at the lowest matching slot. An accepted triple is stored
// at the ring write pointer. The block takes a new request while the previous
// response still waits in the output register. Table contents need no clear
// after reset: only entries below the fill count are ever searched.
module datagram_header_and_duplicate_filter_core #(
   parameter int TABLE_DEPTH = dhdf_pkg::DEF_TABLE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Fields from bit 0 up: datagram_len, rx_magic_a, rx_magic_b, rx_magic_c,
   // version_flag_byte, request_id, source_ip, source_port, zero pad.
   input  logic [dhdf_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0 up: verdict, table_slot, zero pad.
   output logic [dhdf_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_wr_en,
   input  logic [dhdf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dhdf_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import dhdf_pkg::*;

   localparam int PTR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(TABLE_DEPTH - 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_WRITE  = 4'b0100,
      S_HOLD   = 4'b1000
   } state_type;

   // Request field unpacking.
   logic [LEN_W-1:0]  req_len;
   logic [BYTE_W-1:0] req_magic_a;
   logic [BYTE_W-1:0] req_magic_b;
   logic [BYTE_W-1:0] req_magic_c;
   logic [BYTE_W-1:0] req_vf;
   logic [KEY_W-1:0]  req_key;

   assign req_len     = req_tdata[LEN_W-1:0];
   assign req_magic_a = req_tdata[LEN_W +: BYTE_W];
   assign req_magic_b = req_tdata[LEN_W + BYTE_W +: BYTE_W];
   assign req_magic_c = req_tdata[LEN_W + 2*BYTE_W +: BYTE_W];
   assign req_vf      = req_tdata[LEN_W + 3*BYTE_W +: BYTE_W];
   // Key layout: request_id on top, then source_ip, then source_port.
   assign req_key     = {req_tdata[LEN_W + 4*BYTE_W +: ID_W],
                         req_tdata[LEN_W + 4*BYTE_W + ID_W +: IP_W],
                         req_tdata[LEN_W + 4*BYTE_W + ID_W + IP_W +: PORT_W]};

   // Control registers.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MAGIC_FIRST:  cfg_in.magic_first      = csr_wdata[BYTE_W-1:0];
            CSR_MAGIC_SECOND: cfg_in.magic_second     = csr_wdata[BYTE_W-1:0];
            CSR_MAGIC_THIRD:  cfg_in.magic_third      = csr_wdata[BYTE_W-1:0];
            CSR_PROTO_VER:    cfg_in.protocol_version = csr_wdata[VERSION_W-1:0];
            CSR_MIN_LEN:      cfg_in.min_header_len   = csr_wdata[LEN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_first      <= RST_MAGIC;
         cfg_ff.magic_second     <= RST_MAGIC;
         cfg_ff.magic_third      <= RST_MAGIC;
         cfg_ff.protocol_version <= RST_PROTO_VER;
         cfg_ff.min_header_len   <= RST_MIN_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Header tests on the incoming request.
   logic [VERDICT_W-1:0] chk_verdict;

   dhdf_hdr_check u_hdr_check (
      .cfg               (cfg_ff),
      .datagram_len      (req_len),
      .rx_magic_a        (req_magic_a),
      .rx_magic_b        (req_magic_b),
      .rx_magic_c        (req_magic_c),
      .version_flag_byte (req_vf),
      .verdict           (chk_verdict)
   );

   // Sequencer and table state.
   state_type            state_ff, state_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [VERDICT_W-1:0] verdict_ff, verdict_in;
   logic [PTR_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]     filled_ff, filled_in;
   logic [PTR_W-1:0]     wp_ff, wp_in;
   logic [CNT_W-1:0]     issue_cnt_ff, issue_cnt_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [PTR_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0] rsp_verdict_ff, rsp_verdict_in;
   logic [PTR_W-1:0]     rsp_slot_ff, rsp_slot_in;

   logic             req_fire;
   logic             match_now;
   logic             issue_en;
   logic             wr_en;
   logic             out_free;
   logic [KEY_W-1:0] rd_data;

   assign req_tready = state_ff == S_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // The shared comparator: one stored entry per cycle against the key.
   assign match_now = rd_valid_ff && (rd_data == key_ff);
   assign issue_en  = (state_ff == S_SEARCH) && (issue_cnt_ff != filled_ff) && !match_now;
   assign wr_en     = state_ff == S_WRITE;

   dhdf_ring_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ring_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (key_ff),
      .rd_en   (issue_en),
      .rd_addr (issue_cnt_ff[PTR_W-1:0]),
      .rd_data (rd_data)
   );

   // Next-state logic of the sequencer.
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      verdict_in   = verdict_ff;
      slot_in      = slot_ff;
      filled_in    = filled_ff;
      wp_in        = wp_ff;
      issue_cnt_in = issue_en ? issue_cnt_ff + CNT_W'(1) : issue_cnt_ff;
      rd_valid_in  = issue_en;
      rd_idx_in    = issue_en ? issue_cnt_ff[PTR_W-1:0] : rd_idx_ff;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_slot_in    = rsp_slot_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               key_in       = req_key;
               verdict_in   = chk_verdict;
               slot_in      = '0;
               issue_cnt_in = '0;
               state_in     = (chk_verdict == VERDICT_ACCEPT) ? S_SEARCH : S_HOLD;
            end
         end
         S_SEARCH: begin
            if (match_now) begin
               verdict_in = VERDICT_DUPLICATE;
               slot_in    = rd_idx_ff;
               state_in   = S_HOLD;
            end else if ((issue_cnt_ff == filled_ff) && !rd_valid_ff) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            // Store the new triple and advance the ring.
            verdict_in = VERDICT_ACCEPT;
            slot_in    = wp_ff;
            wp_in      = (wp_ff == LAST_PTR) ? '0 : wp_ff + PTR_W'(1);
            filled_in  = (filled_ff == FULL_CNT) ? filled_ff : filled_ff + CNT_W'(1);
            state_in   = S_HOLD;
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
               rsp_slot_in    = slot_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         filled_ff    <= '0;
         wp_ff        <= '0;
         issue_cnt_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         wp_ff        <= wp_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      verdict_ff     <= verdict_in;
      slot_ff        <= slot_in;
      rd_idx_ff      <= rd_idx_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   // Response packing; the slot is reported in its low six bits.
   logic [PTR_W+SLOT_W-1:0] slot_ext;

   assign slot_ext   = {{SLOT_W{1'b0}}, rsp_slot_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}},
                        slot_ext[SLOT_W-1:0], rsp_verdict_ff};

   // The fill count never passes the table depth.
   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FULL_CNT)
      else $error("fill count exceeds table depth");

   // Until the table is full, the ring pointer tracks the fill count.
   a_wp_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (filled_ff != FULL_CNT) |-> (wp_ff == filled_ff[PTR_W-1:0]))
      else $error("write pointer out of step with fill count");

   // Read data is only pending while searching.
   a_rd_in_search: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == S_SEARCH))
      else $error("table read outside of search");

   // A table write grows the fill count unless it is already full.
   a_write_fills: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |=>
         ((filled_ff == $past(filled_ff) + CNT_W'(1)) || (filled_ff == FULL_CNT)))
      else $error("table write did not update fill count");

   // The search never reads beyond the filled entries.
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (issue_cnt_ff <= filled_ff))
      else $error("search ran past filled entries");

endmodule

>>> hdl/dhdf_hdr_check.sv
module dhdf_hdr_check (
   input  dhdf_pkg::cfg_type                  cfg,
   input  logic [dhdf_pkg::LEN_W-1:0]         datagram_len,
   input  logic [dhdf_pkg::BYTE_W-1:0]        rx_magic_a,
   input  logic [dhdf_pkg::BYTE_W-1:0]        rx_magic_b,
   input  logic [dhdf_pkg::BYTE_W-1:0]        rx_magic_c,
   input  logic [dhdf_pkg::BYTE_W-1:0]        version_flag_byte,
   output logic [dhdf_pkg::VERDICT_W-1:0]     verdict
);
   import dhdf_pkg::*;

   logic len_short;
   logic magic_bad;
   logic version_bad;

   // Individual header tests.
   assign len_short   = datagram_len < cfg.min_header_len;
   assign magic_bad   = (rx_magic_a != cfg.magic_first) ||
                        (rx_magic_b != cfg.magic_second) ||
                        (rx_magic_c != cfg.magic_third);
   assign version_bad = version_flag_byte[BYTE_W-1 -: VERSION_W] != cfg.protocol_version;

   // Priority: length first, then magic, then version.
   always_comb begin
      if (len_short) begin
         verdict = VERDICT_SHORT;
      end else if (magic_bad) begin
         verdict = VERDICT_BAD_MAGIC;
      end else if (version_bad) begin
         verdict = VERDICT_BAD_VER;
      end else begin
         verdict = VERDICT_ACCEPT;
      end
   end

endmodule

>>> hdl/dhdf_ring_table.sv
module dhdf_ring_table #(
   parameter int TABLE_DEPTH = dhdf_pkg::DEF_TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]     wr_addr,
   input  logic [dhdf_pkg::KEY_W-1:0]         wr_data,
   input  logic                               rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
   output logic [dhdf_pkg::KEY_W-1:0]         rd_data
);
   import dhdf_pkg::*;

   logic [KEY_W-1:0] entry_mem [TABLE_DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import dhdf_pkg::*;

   localparam int TABLE_DEPTH    = DEF_TABLE_DEPTH;
   localparam int MAX_LEN        = 512;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_REQUESTS = 213;
   localparam int IDLE_PERCENT   = 36;
   localparam int SLACK_CYCLES   = 80;
   localparam int SETTLE_LIMIT   = 50_000;
   localparam int TIMEOUT_CYCLES = 2_500_000;
   localparam int HOLD_AT        = 250;
   localparam int HOLD_CYCLES    = 1500;
   localparam int TRIPLE_HISTORY = 160;

   // Index 7 is not mapped to any register; writes to it must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   // A few fixed triples (request id, source address, source port) for the directed part.
   localparam logic [KEY_W-1:0] TRIPLE_A    = {16'h1234, 32'hC0A8_0001, 16'd5000};
   localparam logic [KEY_W-1:0] TRIPLE_B    = {16'h0BAD, 32'h0A00_0002, 16'd53};
   localparam logic [KEY_W-1:0] TRIPLE_ONES = {KEY_W{1'b1}};
   localparam logic [KEY_W-1:0] TRIPLE_ZERO = '0;

   typedef struct {
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] magic_a;
      logic [BYTE_W-1:0] magic_b;
      logic [BYTE_W-1:0] magic_c;
      logic [BYTE_W-1:0] ver_flags;
      logic [ID_W-1:0]   request_id;
      logic [IP_W-1:0]   source_ip;
      logic [PORT_W-1:0] source_port;
   } header_type;

   typedef struct {
      logic [VERDICT_W-1:0] verdict;
      logic [SLOT_W-1:0]    slot;
   } verdict_rec_type;

   // Tracks the header settings and the recent-request ring, and predicts one
   // verdict per request taken.
   class verdict_board;
      cfg_type          regs;
      logic [KEY_W-1:0] recent_keys [TABLE_DEPTH];
      int               filled;
      int               next_slot;
      verdict_rec_type  pending_verdicts [$];
      int               failures;

      function new();
         regs.magic_first      = RST_MAGIC;
         regs.magic_second     = RST_MAGIC;
         regs.magic_third      = RST_MAGIC;
         regs.protocol_version = RST_PROTO_VER;
         regs.min_header_len   = RST_MIN_LEN;
         filled    = 0;
         next_slot = 0;
         failures  = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_MAGIC_FIRST:  regs.magic_first      = value[BYTE_W-1:0];
            CSR_MAGIC_SECOND: regs.magic_second     = value[BYTE_W-1:0];
            CSR_MAGIC_THIRD:  regs.magic_third      = value[BYTE_W-1:0];
            CSR_PROTO_VER:    regs.protocol_version = value[VERSION_W-1:0];
            CSR_MIN_LEN:      regs.min_header_len   = value[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      // Header tests in priority order, then the search of the filled entries.
      function void note_header(header_type h);
         verdict_rec_type  rec;
         logic [KEY_W-1:0] key;
         bit               found;
         int               i;
         key   = {h.request_id, h.source_ip, h.source_port};
         found = 1'b0;
         rec.slot = '0;
         if (h.len < regs.min_header_len) begin
            rec.verdict = VERDICT_SHORT;
         end else if (h.magic_a != regs.magic_first || h.magic_b != regs.magic_second ||
                      h.magic_c != regs.magic_third) begin
            rec.verdict = VERDICT_BAD_MAGIC;
         end else if (h.ver_flags[7:4] != regs.protocol_version) begin
            rec.verdict = VERDICT_BAD_VER;
         end else begin
            for (i = 0; i < filled && !found; i++) begin
               if (recent_keys[i] == key) begin
                  found    = 1'b1;
                  rec.slot = SLOT_W'(i);
               end
            end
            if (found) begin
               rec.verdict = VERDICT_DUPLICATE;
            end else begin
               // New triple goes to the ring pointer, overwriting the oldest once full.
               recent_keys[next_slot] = key;
               rec.slot    = SLOT_W'(next_slot);
               rec.verdict = VERDICT_ACCEPT;
               next_slot   = (next_slot + 1) % TABLE_DEPTH;
               if (filled < TABLE_DEPTH) filled++;
            end
         end
         pending_verdicts.push_back(rec);
      endfunction

      function void check_verdict(logic [VERDICT_W-1:0] verdict, logic [SLOT_W-1:0] slot);
         verdict_rec_type want;
         if (pending_verdicts.size() == 0) begin
            $error("response with no request waiting: verdict %0d table_slot %0d",
                   verdict, slot);
            failures++;
            return;
         end
         want = pending_verdicts.pop_front();
         if (verdict != want.verdict) begin
            $error("verdict mismatch: expected %0d, actual %0d", want.verdict, verdict);
            failures++;
         end
         if (slot != want.slot) begin
            $error("table_slot mismatch: expected %0d, actual %0d", want.slot, slot);
            failures++;
         end
      endfunction

      function int waiting();
         return pending_verdicts.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   verdict_board     board = new();
   logic [KEY_W-1:0] recent_triples [$];
   int               requests_sent = 0;

   datagram_header_and_duplicate_filter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog for a hung handshake.
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [REQ_TDATA_W-1:0] pack_header(input header_type h);
      logic [REQ_TDATA_W-1:0] word;
      word = '0;
      word[REQ_FIELDS_W-1:0] = {h.source_port, h.source_ip, h.request_id, h.ver_flags,
                                h.magic_c, h.magic_b, h.magic_a, h.len};
      return word;
   endfunction

   function automatic header_type header_of(input int len, input logic [BYTE_W-1:0] a,
                                            input logic [BYTE_W-1:0] b,
                                            input logic [BYTE_W-1:0] c,
                                            input logic [BYTE_W-1:0] vf,
                                            input logic [KEY_W-1:0] triple);
      header_type h;
      h.len       = LEN_W'(len);
      h.magic_a   = a;
      h.magic_b   = b;
      h.magic_c   = c;
      h.ver_flags = vf;
      {h.request_id, h.source_ip, h.source_port} = triple;
      return h;
   endfunction

   // Mostly headers that pass the tests under the current settings, with fresh,
   // repeated or nearly repeated triples; the rest carry one or two flaws.
   function automatic header_type random_header();
      header_type h;
      cfg_type    c;
      int         pick;
      c    = board.regs;
      pick = $urandom_range(99);
      h.len       = LEN_W'($urandom_range(MAX_LEN, int'(c.min_header_len)));
      h.magic_a   = c.magic_first;
      h.magic_b   = c.magic_second;
      h.magic_c   = c.magic_third;
      h.ver_flags = {c.protocol_version, 4'($urandom)};
      if (pick >= 50 && pick < 78 && recent_triples.size() > 0) begin
         {h.request_id, h.source_ip, h.source_port} =
            recent_triples[$urandom_range(recent_triples.size() - 1)];
         // A near miss differs from a stored triple in a single bit.
         if (pick >= 72) begin
            case ($urandom_range(2))
               0: h.request_id  ^= ID_W'(1) << $urandom_range(ID_W - 1);
               1: h.source_ip   ^= IP_W'(1) << $urandom_range(IP_W - 1);
               default: h.source_port ^= PORT_W'(1) << $urandom_range(PORT_W - 1);
            endcase
         end
      end else begin
         h.request_id  = ID_W'($urandom);
         h.source_ip   = $urandom;
         h.source_port = PORT_W'($urandom);
      end
      recent_triples.push_back({h.request_id, h.source_ip, h.source_port});
      if (recent_triples.size() > TRIPLE_HISTORY) void'(recent_triples.pop_front());
      if (pick >= 78) begin
         repeat ($urandom_range(2, 1)) begin
            case ($urandom_range(3))
               0: if (c.min_header_len != 0)
                     h.len = LEN_W'($urandom_range(int'(c.min_header_len) - 1, 0));
               1: case ($urandom_range(2))
                     0: h.magic_a ^= BYTE_W'($urandom_range(255, 1));
                     1: h.magic_b ^= BYTE_W'($urandom_range(255, 1));
                     default: h.magic_c ^= BYTE_W'($urandom_range(255, 1));
                  endcase
               2: h.ver_flags[7:4] = c.protocol_version + 4'($urandom_range(15, 1));
               default: begin
                  h.len       = LEN_W'($urandom_range(MAX_LEN, 0));
                  h.magic_a   = BYTE_W'($urandom);
                  h.magic_b   = BYTE_W'($urandom);
                  h.magic_c   = BYTE_W'($urandom);
                  h.ver_flags = BYTE_W'($urandom);
               end
            endcase
         end
      end
      return h;
   endfunction

   // Offers one request and holds it until taken, then maybe idles a few cycles.
   task automatic offer(input header_type h);
      req_tdata  <= pack_header(h);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_header(h);
      requests_sent++;
      if (requests_sent < 500 || requests_sent >= 700) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // Lets every outstanding verdict come back, then a few idle cycles more.
   task automatic settle();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (board.waiting() != 0 && guard < SETTLE_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SLACK_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.write_register(idx, value);
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] m1, input logic [CSR_DATA_W-1:0] m2,
                                 input logic [CSR_DATA_W-1:0] m3, input logic [CSR_DATA_W-1:0] ver,
                                 input logic [CSR_DATA_W-1:0] min_len);
      write_register(CSR_MAGIC_FIRST, m1);
      write_register(CSR_MAGIC_SECOND, m2);
      write_register(CSR_MAGIC_THIRD, m3);
      write_register(CSR_PROTO_VER, ver);
      write_register(CSR_MIN_LEN, min_len);
   endtask

   // Response side: checks each verdict, idles at random, holds off once for a
   // long stretch so the block backs up, and has one stretch of steady readiness.
   initial begin : response_sink
      int taken;
      int hold_left;
      taken     = 0;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            board.check_verdict(rsp_tdata[VERDICT_W-1:0], rsp_tdata[VERDICT_W +: SLOT_W]);
            taken++;
            if (taken == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (taken >= 900 && taken < 1100) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin : stimulus
      int phase;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_wr_en  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests under the reset settings: magic 0/0/0, version 1, minimum 8.
      offer(header_of(7, 8'h00, 8'h00, 8'h00, 8'h10, TRIPLE_B));
      offer(header_of(8, 8'h00, 8'h00, 8'h00, 8'h10, TRIPLE_A));
      offer(header_of(8, 8'h00, 8'h00, 8'h00, 8'h10, TRIPLE_A));
      offer(header_of(8, 8'h01, 8'h00, 8'h00, 8'h10, TRIPLE_B));
      offer(header_of(8, 8'h00, 8'h00, 8'h80, 8'h10, TRIPLE_B));
      // Priority: short beats bad magic, bad magic beats bad version,
      // bad version beats duplicate.
      offer(header_of(3, 8'hFF, 8'h00, 8'h00, 8'hF0, TRIPLE_B));
      offer(header_of(8, 8'h00, 8'h01, 8'h00, 8'h20, TRIPLE_A));
      offer(header_of(8, 8'h00, 8'h00, 8'h00, 8'h2F, TRIPLE_A));
      offer(header_of(MAX_LEN, 8'h00, 8'h00, 8'h00, 8'h1F, TRIPLE_ONES));
      offer(header_of(0, 8'h00, 8'h00, 8'h00, 8'h10, TRIPLE_B));
      offer(header_of(8, 8'h00, 8'h00, 8'h00, 8'h10, TRIPLE_ZERO));
      offer(header_of(8, 8'h00, 8'h00, 8'h00, 8'h10, TRIPLE_ZERO));
      offer(header_of(8, 8'h00, 8'h00, 8'h00, 8'h10, TRIPLE_A ^ KEY_W'(1)));
      offer(header_of(8, 8'h00, 8'h00, 8'h00, 8'h10, TRIPLE_A ^ (KEY_W'(1) << 47)));
      offer(header_of(8, 8'h00, 8'h00, 8'h00, 8'h1A, TRIPLE_ONES));

      // All-ones settings with a zero minimum; the first and third magic writes and the
      // version write carry spare high data bits, and the unmapped index is written once.
      settle();
      apply_settings(10'h3FF, 10'h0FF, 10'h2FF, 10'h3FF, 10'd0);
      write_register(CSR_UNMAPPED, 10'h155);
      offer(header_of(0, 8'hFF, 8'hFF, 8'hFF, 8'hF0, TRIPLE_B));
      offer(header_of(0, 8'hFF, 8'hFF, 8'hFE, 8'hF0, TRIPLE_B));
      offer(header_of(MAX_LEN, 8'hFF, 8'hFF, 8'hFF, 8'hE0, TRIPLE_B));

      // All-zero settings with a minimum length of MAX_LEN.
      settle();
      apply_settings(10'd0, 10'd0, 10'd0, 10'd0, 10'd512);
      offer(header_of(MAX_LEN - 1, 8'h00, 8'h00, 8'h00, 8'h0F, TRIPLE_ONES ^ KEY_W'(3)));
      offer(header_of(MAX_LEN, 8'h00, 8'h00, 8'h00, 8'h00, TRIPLE_ONES ^ KEY_W'(3)));
      offer(header_of(MAX_LEN, 8'h00, 8'h00, 8'h00, 8'h05, TRIPLE_A));

      // Random phases, each under its own settings.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case (phase)
            1: apply_settings(10'd255, 10'd255, 10'd255, 10'd15, 10'd0);
            2: apply_settings(10'd0, 10'd0, 10'd0, 10'd0, 10'd512);
            3: apply_settings(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                              CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                              CSR_DATA_W'($urandom_range(MAX_LEN, 0)));
            4: apply_settings(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                              CSR_DATA_W'($urandom), 10'd1, 10'd8);
            default: apply_settings(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                                    CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                                    CSR_DATA_W'($urandom_range(64, 0)));
         endcase
         repeat (PHASE_REQUESTS) offer(random_header());
      end

      settle();
      if (board.waiting() != 0) begin
         $error("%0d verdicts never arrived", board.waiting());
         board.failures++;
      end
      if (board.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/dhdf_pkg.sv
hdl/dhdf_hdr_check.sv
hdl/dhdf_ring_table.sv
hdl/datagram_header_and_duplicate_filter_core.sv
tb/testbench.sv
